FILE: design/s2cd_pkg.sv
// Package: widths, reciprocal constants and calendar tables for the seconds to date converter.
`default_nettype none

package s2cd_pkg;

	localparam int EPOCH_YEAR    = 2020;
	localparam int EPOCH_WEEKDAY = 3;

	localparam int SECS_W  = 32;
	localparam int DAYS_W  = 16;
	localparam int TOD_W   = 17;
	localparam int YOFF_W  = 8;
	localparam int YEAR_W  = 12;
	localparam int MONTH_W = 4;
	localparam int DOM_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int WDAY_W  = 3;
	localparam int DOY_W   = 9;
	localparam int REM_W   = 10;
	localparam int MSR_W   = 12;

	localparam int SECS_PER_DAY  = 86400;
	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_MIN  = 60;
	localparam int YEAR_DAYS     = 365;
	localparam int WEEK_DAYS     = 7;

	// 86400 = 675 * 2^7: drop the low seven bits, then divide by 675
	localparam int DAY_PRE_SHIFT = 7;
	localparam int DAY_ODD_DIV   = 675;

	// ceiling reciprocals, exact over the operand range used
	localparam int DAY_K  = 35;
	localparam int YEAR_K = 25;
	localparam int WEEK_K = 19;
	localparam int HOUR_K = 29;
	localparam int MIN_K  = 18;

	localparam logic [25:0] DAY_RECIP =
		26'(((64'd1 << DAY_K) + 64'(DAY_ODD_DIV) - 64'd1) / 64'(DAY_ODD_DIV));
	localparam logic [16:0] YEAR_RECIP =
		17'(((64'd1 << YEAR_K) + 64'(YEAR_DAYS) - 64'd1) / 64'(YEAR_DAYS));
	localparam logic [16:0] WEEK_RECIP =
		17'(((64'd1 << WEEK_K) + 64'(WEEK_DAYS) - 64'd1) / 64'(WEEK_DAYS));
	localparam logic [17:0] HOUR_RECIP =
		18'(((64'd1 << HOUR_K) + 64'(SECS_PER_HOUR) - 64'd1) / 64'(SECS_PER_HOUR));
	localparam logic [12:0] MIN_RECIP =
		13'(((64'd1 << MIN_K) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));

	// accept edge to result strobe edge
	localparam int PIPE_LATENCY = 8;

	typedef logic [5:0] leap_cnt_tab_t [256];
	typedef logic [255:0] leap_flag_vec_t;
	typedef logic [DOY_W-1:0] month_start_tab_t [12];

	localparam month_start_tab_t MONTH_START = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	function automatic logic is_leap_year(input int yy);
		return ((yy % 4 == 0) && (yy % 100 != 0)) || (yy % 400 == 0);
	endfunction

	function automatic leap_flag_vec_t build_leap_flag();
		leap_flag_vec_t v;
		for (int i = 0; i < 256; i++) begin
			v[i] = is_leap_year(EPOCH_YEAR + i);
		end
		return v;
	endfunction

	// entry i: leap years in EPOCH_YEAR .. EPOCH_YEAR + i - 1
	function automatic leap_cnt_tab_t build_leap_cnt();
		leap_cnt_tab_t t;
		int n;
		n = 0;
		for (int i = 0; i < 256; i++) begin
			t[i] = 6'(n);
			n = n + (is_leap_year(EPOCH_YEAR + i) ? 1 : 0);
		end
		return t;
	endfunction

	localparam leap_flag_vec_t LEAP_FLAG = build_leap_flag();
	localparam leap_cnt_tab_t  LEAP_CNT  = build_leap_cnt();

	function automatic logic [DOY_W-1:0] month_first(input logic [MONTH_W-1:0] m,
		input logic leap);
		return MONTH_START[m] + DOY_W'((m >= MONTH_W'(2)) && leap);
	endfunction

endpackage

`default_nettype wire

FILE: design/s2cd_days.sv
// Day split: seconds into whole days and seconds of the day, stages 1 to 3.
`default_nettype none

module s2cd_days import s2cd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [SECS_W-1:0] seconds,
	output logic              out_valid,
	output logic [DAYS_W-1:0] days,
	output logic [TOD_W-1:0]  tod
);

	logic [50:0]       day_prod;
	logic              v_s1, v_s2, v_s3;
	logic [SECS_W-1:0] secs_s1, secs_s2;
	logic [DAYS_W-1:0] days_s1, days_s2, days_s3;
	logic [SECS_W-1:0] dsec_s2;
	logic [TOD_W-1:0]  tod_s3;

	assign day_prod = 51'(seconds[SECS_W-1:DAY_PRE_SHIFT]) * 51'(DAY_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			secs_s1 <= seconds;
			days_s1 <= day_prod[DAY_K+DAYS_W-1:DAY_K];
		end
		if (v_s1) begin
			secs_s2 <= secs_s1;
			days_s2 <= days_s1;
			dsec_s2 <= SECS_W'(days_s1 * SECS_W'(SECS_PER_DAY));
		end
		if (v_s2) begin
			days_s3 <= days_s2;
			tod_s3  <= TOD_W'(secs_s2 - dsec_s2);
		end
	end

	assign out_valid = v_s3;
	assign days      = days_s3;
	assign tod       = tod_s3;

endmodule

`default_nettype wire

FILE: design/s2cd_date.sv
// Date path: day count into year, month, day of month and weekday, stages 4 to 8.
`default_nettype none

module s2cd_date import s2cd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [DAYS_W-1:0]  days,
	output logic               out_valid,
	output logic [YEAR_W-1:0]  year,
	output logic [MONTH_W-1:0] month,
	output logic [DOM_W-1:0]   day_of_month,
	output logic [WDAY_W-1:0]  weekday
);

	logic [32:0]        year_prod;
	logic [16:0]        wsum;
	logic [33:0]        week_prod;
	logic [16:0]        rem_full;
	logic [YOFF_W-1:0]  yprev;
	logic               flag_prev;
	logic [MONTH_W-1:0] m_cnt;

	logic               v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [DAYS_W-1:0]  days_s4;
	logic [YOFF_W-1:0]  yq_s4, yq_s5;
	logic [16:0]        wsum_s4;
	logic [12:0]        wq_s4;
	logic [REM_W-1:0]   rem_s5;
	logic [WDAY_W-1:0]  wd_s5, wd_s6, wd_s7, wd_s8;
	logic [YEAR_W-1:0]  year_s6, year_s7, year_s8;
	logic [DOY_W-1:0]   doy_s6, doy_s7;
	logic               leap_s6, leap_s7;
	logic [MONTH_W-1:0] mon_s7, mon_s8;
	logic [DOM_W-1:0]   dom_s8;

	assign year_prod = 33'(days) * 33'(YEAR_RECIP);
	assign wsum      = 17'(days) + 17'(EPOCH_WEEKDAY);
	assign week_prod = 34'(wsum) * 34'(WEEK_RECIP);

	assign rem_full  = 17'(days_s4) - 17'(yq_s4) * 17'(YEAR_DAYS) - 17'(LEAP_CNT[yq_s4]);
	assign yprev     = yq_s5 - YOFF_W'(1);
	assign flag_prev = LEAP_FLAG[yprev];

	always_comb begin
		m_cnt = '0;
		for (int i = 1; i < 12; i++) begin
			if (doy_s6 >= month_first(MONTH_W'(i), leap_s6)) begin
				m_cnt = m_cnt + MONTH_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s4 <= in_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			days_s4 <= days;
			yq_s4   <= year_prod[YEAR_K+YOFF_W-1:YEAR_K];
			wsum_s4 <= wsum;
			wq_s4   <= week_prod[WEEK_K+12:WEEK_K];
		end
		if (v_s4) begin
			yq_s5  <= yq_s4;
			rem_s5 <= rem_full[REM_W-1:0];
			wd_s5  <= WDAY_W'(wsum_s4 - 17'(wq_s4) * 17'(WEEK_DAYS));
		end
		if (v_s5) begin
			wd_s6 <= wd_s5;
			if (rem_s5[REM_W-1]) begin
				// step back one year and count from its end
				year_s6 <= YEAR_W'(EPOCH_YEAR) + YEAR_W'(yq_s5) - YEAR_W'(1);
				doy_s6  <= DOY_W'(rem_s5 + REM_W'(YEAR_DAYS) + REM_W'(flag_prev));
				leap_s6 <= flag_prev;
			end else begin
				year_s6 <= YEAR_W'(EPOCH_YEAR) + YEAR_W'(yq_s5);
				doy_s6  <= rem_s5[DOY_W-1:0];
				leap_s6 <= LEAP_FLAG[yq_s5];
			end
		end
		if (v_s6) begin
			wd_s7   <= wd_s6;
			year_s7 <= year_s6;
			doy_s7  <= doy_s6;
			leap_s7 <= leap_s6;
			mon_s7  <= m_cnt;
		end
		if (v_s7) begin
			wd_s8   <= wd_s7;
			year_s8 <= year_s7;
			mon_s8  <= mon_s7 + MONTH_W'(1);
			dom_s8  <= DOM_W'(doy_s7 - month_first(mon_s7, leap_s7) + DOY_W'(1));
		end
	end

	assign out_valid    = v_s8;
	assign year         = year_s8;
	assign month        = mon_s8;
	assign day_of_month = dom_s8;
	assign weekday      = wd_s8;

endmodule

`default_nettype wire

FILE: design/s2cd_clock.sv
// Time path: seconds of the day into hour, minute and second, stages 4 to 8.
`default_nettype none

module s2cd_clock import s2cd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [TOD_W-1:0]  tod,
	output logic              out_valid,
	output logic [HOUR_W-1:0] hour,
	output logic [MIN_W-1:0]  minute,
	output logic [SEC_W-1:0]  second
);

	logic [34:0]       hour_prod;
	logic [24:0]       min_prod;

	logic              v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [TOD_W-1:0]  tod_s4;
	logic [HOUR_W-1:0] hr_s4, hr_s5, hr_s6, hr_s7, hr_s8;
	logic [MSR_W-1:0]  msr_s5, msr_s6;
	logic [MIN_W-1:0]  mi_s6, mi_s7, mi_s8;
	logic [SEC_W-1:0]  sec_s7, sec_s8;

	assign hour_prod = 35'(tod) * 35'(HOUR_RECIP);
	assign min_prod  = 25'(msr_s5) * 25'(MIN_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s4 <= in_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			tod_s4 <= tod;
			hr_s4  <= hour_prod[HOUR_K+HOUR_W-1:HOUR_K];
		end
		if (v_s4) begin
			hr_s5  <= hr_s4;
			msr_s5 <= MSR_W'(tod_s4 - TOD_W'(hr_s4) * TOD_W'(SECS_PER_HOUR));
		end
		if (v_s5) begin
			hr_s6  <= hr_s5;
			msr_s6 <= msr_s5;
			mi_s6  <= min_prod[MIN_K+MIN_W-1:MIN_K];
		end
		if (v_s6) begin
			hr_s7  <= hr_s6;
			mi_s7  <= mi_s6;
			sec_s7 <= SEC_W'(msr_s6 - MSR_W'(mi_s6) * MSR_W'(SECS_PER_MIN));
		end
		if (v_s7) begin
			hr_s8  <= hr_s7;
			mi_s8  <= mi_s7;
			sec_s8 <= sec_s7;
		end
	end

	assign out_valid = v_s8;
	assign hour      = hr_s8;
	assign minute    = mi_s8;
	assign second    = sec_s8;

endmodule

`default_nettype wire

FILE: design/seconds_to_calendar_date.sv
// Top level: epoch seconds to Gregorian date, time of day and weekday.
//
//   channel   handshake        payload
//   command   start / busy     seconds
//   result    done (strobe)    year month day_of_month hour minute second weekday
//
// One transfer is accepted per cycle while busy is low; each result strobes done
// when its transfer has passed the eight register stages of the chained reciprocal
// multiplies (day split, year and hour, minutes), one result per transfer, in order.
// busy is high during reset and the first cycle after; there is no other wait.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module seconds_to_calendar_date import s2cd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [SECS_W-1:0]  seconds,
	output logic               done,
	output logic [YEAR_W-1:0]  year,
	output logic [MONTH_W-1:0] month,
	output logic [DOM_W-1:0]   day_of_month,
	output logic [HOUR_W-1:0]  hour,
	output logic [MIN_W-1:0]   minute,
	output logic [SEC_W-1:0]   second,
	output logic [WDAY_W-1:0]  weekday
);

	logic              busy_q;
	logic              accept;
	logic              split_valid;
	logic [DAYS_W-1:0] split_days;
	logic [TOD_W-1:0]  split_tod;
	logic              date_valid;
	logic              clock_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	s2cd_days u_days (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.seconds   (seconds),
		.out_valid (split_valid),
		.days      (split_days),
		.tod       (split_tod)
	);

	s2cd_date u_date (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (split_valid),
		.days         (split_days),
		.out_valid    (date_valid),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.weekday      (weekday)
	);

	s2cd_clock u_clock (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (split_valid),
		.tod       (split_tod),
		.out_valid (clock_valid),
		.hour      (hour),
		.minute    (minute),
		.second    (second)
	);

	assign done = date_valid && clock_valid;

`ifndef SYNTH
	a_paths_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		date_valid == clock_valid)
		else $error("date and time paths out of step");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##PIPE_LATENCY done)
		else $error("transfer produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, PIPE_LATENCY))
		else $error("result without a transfer");

	a_fields_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (month >= 4'd1 && month <= 4'd12 && day_of_month != 5'd0 &&
			hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59 && weekday <= 3'd6))
		else $error("result field out of range");
`endif

endmodule

`default_nettype wire
